// ===== src/lcapw_pkg.sv =====
// Shared constants and types for the lowest common ancestor parent walk block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lcapw_pkg;

	localparam int NODE_COUNT_DEF = 1024;
	localparam int NODE_W         = 10;
	localparam int PAR_W          = 11;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [PAR_W-1:0] NO_NODE = {PAR_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK_A,
		ST_WALK_B,
		ST_CMP_ISSUE,
		ST_CMP
	} state_t;

endpackage
`default_nettype wire

// ===== src/lowest_common_ancestor_parent_walk_top.sv =====
// Lowest common ancestor by parent walk: parent table memory, walk stack memory
// and the sequencer around them. Depends on lcapw_pkg.
//
// Usage:
//   Command channel: a word is taken at a rising edge with start high and busy
//   low. operation selects load (write the parent of node_a) or query (common
//   ancestor of node_a and node_b_or_parent).
//   A load gives no result and leaves busy low.
//   A query raises busy. The block walks the path of node_a, then that of
//   node_b_or_parent, one node a cycle through the parent table read port, then
//   pops both paths from the root end, one node pair a cycle through the two
//   stack read ports.
//   A walk that reaches NODE_COUNT + 1 nodes stops at once and reports
//   walk_error with ancestor -1.
//   The result is shown on ancestor and walk_error for exactly one cycle with
//   result_strobe high; busy falls in that same cycle, so the next command may
//   be taken while the result is shown. The receiver cannot stall.
//   Reset clears the sequencer and the strobe; the parent table keeps no reset
//   value and must be loaded before it is queried.
`timescale 1ns / 1ps
`default_nettype none
module lowest_common_ancestor_parent_walk_top #(
	parameter int NODE_COUNT = lcapw_pkg::NODE_COUNT_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	output logic                                  busy,
	input  wire                                   operation,
	input  wire  [lcapw_pkg::NODE_W-1:0]          node_a,
	input  wire  signed [lcapw_pkg::PAR_W-1:0]    node_b_or_parent,
	output logic                                  result_strobe,
	output logic signed [lcapw_pkg::PAR_W-1:0]    ancestor,
	output logic                                  walk_error
);
	import lcapw_pkg::*;

	localparam int AW        = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int LW        = $clog2(NODE_COUNT + 1);
	localparam int STK_DEPTH = 2 ** (AW + 1);
	localparam logic [31:0] NC32 = 32'(NODE_COUNT);
	localparam logic [LW-1:0] LEN_MAX = LW'(NODE_COUNT);

	state_t state_q, state_d;

	logic [PAR_W-1:0]  tbl [0:NODE_COUNT-1];
	logic [NODE_W-1:0] stk [0:STK_DEPTH-1];

	logic [PAR_W-1:0]  tbl_rd_q;
	logic [NODE_W-1:0] stk_a_q, stk_b_q;

	logic [PAR_W-1:0]  start_q, start_b_q, ans_q;
	logic              first_q;
	logic [LW-1:0]     len_q, la_q, lb_q;

	logic              strobe_q, err_q;
	logic [PAR_W-1:0]  anc_q;

	logic [PAR_W-1:0]  cur;
	logic              cur_valid, walking, overflow, at_end, push;
	logic              tbl_we, stk_re, empty, eq, more;
	logic              fin, fin_err;
	logic [PAR_W-1:0]  fin_anc;
	logic [LW-1:0]     la_m1, lb_m1;
	logic [AW-1:0]     tbl_ra, tbl_wa;
	logic [AW:0]       stk_wa;

	assign cur       = first_q ? start_q : tbl_rd_q;
	assign cur_valid = !cur[PAR_W-1] && (32'(cur[NODE_W-1:0]) < NC32);
	assign walking   = (state_q == ST_WALK_A) || (state_q == ST_WALK_B);
	assign overflow  = walking && cur_valid && (len_q == LEN_MAX);
	assign at_end    = walking && !cur_valid;
	assign push      = walking && cur_valid && (len_q != LEN_MAX);
	assign tbl_ra    = AW'(cur[NODE_W-1:0]);
	assign tbl_wa    = AW'(node_a);
	assign tbl_we    = (state_q == ST_IDLE) && start && (operation == OP_LOAD)
		&& (32'(node_a) < NC32);
	assign stk_wa    = {state_q == ST_WALK_B, len_q[AW-1:0]};
	assign la_m1     = la_q - LW'(1);
	assign lb_m1     = lb_q - LW'(1);
	assign empty     = (la_q == '0) || (lb_q == '0);
	assign eq        = (stk_a_q == stk_b_q);
	assign more      = eq && !empty;

	always_comb begin
		state_d = state_q;
		stk_re  = 1'b0;
		fin     = 1'b0;
		fin_err = 1'b0;
		fin_anc = NO_NODE;
		case (state_q)
			ST_IDLE: begin
				if (start && (operation == OP_QUERY)) begin
					state_d = ST_WALK_A;
				end
			end
			ST_WALK_A: begin
				if (overflow) begin
					fin     = 1'b1;
					fin_err = 1'b1;
					state_d = ST_IDLE;
				end else if (at_end) begin
					state_d = ST_WALK_B;
				end
			end
			ST_WALK_B: begin
				if (overflow) begin
					fin     = 1'b1;
					fin_err = 1'b1;
					state_d = ST_IDLE;
				end else if (at_end) begin
					state_d = ST_CMP_ISSUE;
				end
			end
			ST_CMP_ISSUE: begin
				if (empty) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else begin
					stk_re  = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (more) begin
					stk_re = 1'b1;
				end else begin
					fin     = 1'b1;
					fin_anc = eq ? {1'b0, stk_a_q} : ans_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// parent table: one write port for loads, one read port for the walk
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl[tbl_wa] <= node_b_or_parent;
		end
		if (push) begin
			tbl_rd_q <= tbl[tbl_ra];
		end
	end

	// walk stacks: path a in the low half, path b in the high half
	always_ff @(posedge clk) begin
		if (push) begin
			stk[stk_wa] <= cur[NODE_W-1:0];
		end
		if (stk_re) begin
			stk_a_q <= stk[{1'b0, la_m1[AW-1:0]}];
			stk_b_q <= stk[{1'b1, lb_m1[AW-1:0]}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= 1'b1;
			len_q    <= '0;
			la_q     <= '0;
			lb_q     <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= fin;
			case (state_q)
				ST_IDLE: begin
					first_q <= 1'b1;
					len_q   <= '0;
				end
				ST_WALK_A, ST_WALK_B: begin
					if (push) begin
						len_q   <= len_q + LW'(1);
						first_q <= 1'b0;
					end else if (at_end) begin
						len_q   <= '0;
						first_q <= 1'b1;
						if (state_q == ST_WALK_A) begin
							la_q <= len_q;
						end else begin
							lb_q <= len_q;
						end
					end
				end
				ST_CMP_ISSUE: begin
					if (!empty) begin
						la_q <= la_m1;
						lb_q <= lb_m1;
					end
				end
				ST_CMP: begin
					if (more) begin
						la_q <= la_m1;
						lb_q <= lb_m1;
					end
				end
				default: begin
					len_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start && (operation == OP_QUERY)) begin
			start_q   <= {1'b0, node_a};
			start_b_q <= node_b_or_parent;
			ans_q     <= NO_NODE;
		end else if ((state_q == ST_WALK_A) && at_end) begin
			start_q <= start_b_q;
		end else if ((state_q == ST_CMP) && eq) begin
			ans_q <= {1'b0, stk_a_q};
		end
		if (fin) begin
			anc_q <= fin_anc;
			err_q <= fin_err;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign ancestor      = anc_q;
	assign walk_error    = err_q;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for lowest_common_ancestor_parent_walk_top: directed words,
// then random forests and queries checked against a local parent-walk predictor.
// Depends on lcapw_pkg and the top level of the block.
`timescale 1ns / 1ps
module testbench;
	import lcapw_pkg::*;

	localparam int NODES            = NODE_COUNT_DEF;
	localparam int STALL_LIMIT      = 20000;
	localparam int RANDOM_PER_PHASE = 55;

	typedef struct packed {
		logic signed [PAR_W-1:0] ancestor;
		logic                    walk_error;
	} lca_answer_t;

	typedef struct packed {
		logic                    op;
		logic [NODE_W-1:0]       node;
		logic signed [PAR_W-1:0] other;
		logic                    typed;
		logic signed [PAR_W-1:0] ancestor;
		logic                    walk_error;
	} directed_word_t;

	localparam directed_word_t DIRECTED_WORDS [25] = '{
		'{OP_LOAD,  10'd0,    NO_NODE,     1'b0, NO_NODE,     1'b0},
		'{OP_LOAD,  10'd1023, 11'sd0,      1'b0, NO_NODE,     1'b0},
		'{OP_LOAD,  10'd1,    11'sd0,      1'b0, NO_NODE,     1'b0},
		'{OP_LOAD,  10'd2,    11'sd1,      1'b0, NO_NODE,     1'b0},
		'{OP_LOAD,  10'd512,  11'h400,     1'b0, NO_NODE,     1'b0},
		'{OP_QUERY, 10'd0,    11'sd0,      1'b1, 11'sd0,      1'b0},
		'{OP_QUERY, 10'd1023, 11'sd2,      1'b0, NO_NODE,     1'b0},
		'{OP_QUERY, 10'd2,    NO_NODE,     1'b1, NO_NODE,     1'b0},
		'{OP_QUERY, 10'd512,  11'h400,     1'b1, NO_NODE,     1'b0},
		'{OP_QUERY, 10'd0,    11'sd512,    1'b1, NO_NODE,     1'b0},
		'{OP_QUERY, 10'd2,    11'sd1,      1'b0, NO_NODE,     1'b0},
		'{OP_QUERY, 10'd1023, 11'sd1023,   1'b1, 11'sd1023,   1'b0},
		'{OP_LOAD,  10'd700,  11'sd512,    1'b0, NO_NODE,     1'b0},
		'{OP_LOAD,  10'd341,  11'sd700,    1'b0, NO_NODE,     1'b0},
		'{OP_QUERY, 10'd341,  11'sd512,    1'b0, NO_NODE,     1'b0},
		'{OP_LOAD,  10'd5,    11'sd5,      1'b0, NO_NODE,     1'b0},
		'{OP_QUERY, 10'd5,    11'sd0,      1'b1, NO_NODE,     1'b1},
		'{OP_QUERY, 10'd0,    11'sd5,      1'b1, NO_NODE,     1'b1},
		'{OP_LOAD,  10'd7,    NO_NODE,     1'b0, NO_NODE,     1'b0},
		'{OP_LOAD,  10'd6,    11'sd7,      1'b0, NO_NODE,     1'b0},
		'{OP_LOAD,  10'd7,    11'sd6,      1'b0, NO_NODE,     1'b0},
		'{OP_QUERY, 10'd6,    11'sd341,    1'b1, NO_NODE,     1'b1},
		'{OP_LOAD,  10'd5,    NO_NODE,     1'b0, NO_NODE,     1'b0},
		'{OP_LOAD,  10'd7,    NO_NODE,     1'b0, NO_NODE,     1'b0},
		'{OP_QUERY, 10'd6,    11'sd2,      1'b0, NO_NODE,     1'b0}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    operation;
	logic [NODE_W-1:0]       node_a;
	logic signed [PAR_W-1:0] node_b_or_parent;
	logic                    result_strobe;
	logic signed [PAR_W-1:0] ancestor;
	logic                    walk_error;

	logic signed [PAR_W-1:0] parent_copy [NODES];
	bit                      node_loaded [NODES];
	int                      loaded_nodes [$];
	int                      climb_path [2][NODES];
	lca_answer_t             answers_due [$];
	int                      idle_pct;
	int                      mismatches;
	int                      stall_cycles;

	lowest_common_ancestor_parent_walk_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.operation        (operation),
		.node_a           (node_a),
		.node_b_or_parent (node_b_or_parent),
		.result_strobe    (result_strobe),
		.ancestor         (ancestor),
		.walk_error       (walk_error)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic lca_answer_t predict_ancestor(input int first, input int second);
		lca_answer_t ans;
		int          cur;
		int          depth [2];
		int          ia;
		int          ib;
		bit          overflow;
		overflow = 1'b0;
		depth[0] = 0;
		depth[1] = 0;
		for (int k = 0; k < 2 && !overflow; k++) begin
			cur = (k == 0) ? first : second;
			while (!overflow && cur >= 0 && cur < NODES) begin
				if (depth[k] >= NODES) begin
					overflow = 1'b1;
				end else begin
					climb_path[k][depth[k]] = cur;
					depth[k]++;
					cur = int'(parent_copy[cur]);
				end
			end
		end
		ans.walk_error = overflow;
		ans.ancestor   = NO_NODE;
		if (!overflow) begin
			ia = depth[0];
			ib = depth[1];
			while (ia > 0 && ib > 0 && climb_path[0][ia-1] == climb_path[1][ib-1]) begin
				ans.ancestor = PAR_W'(climb_path[0][ia-1]);
				ia--;
				ib--;
			end
		end
		return ans;
	endfunction

	task automatic apply_word(input logic op, input logic [NODE_W-1:0] node,
			input logic signed [PAR_W-1:0] other, input logic typed,
			input logic signed [PAR_W-1:0] typed_ancestor, input logic typed_error);
		lca_answer_t typed_answer;
		typed_answer.ancestor   = typed_ancestor;
		typed_answer.walk_error = typed_error;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start            <= 1'b1;
		operation        <= op;
		node_a           <= node;
		node_b_or_parent <= other;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (op == OP_LOAD) begin
			if (int'(node) < NODES) begin
				parent_copy[node] = other;
				if (!node_loaded[node]) begin
					node_loaded[node] = 1'b1;
					loaded_nodes = {loaded_nodes, int'(node)};
				end
			end
		end else begin
			if (!typed) begin
				typed_answer = predict_ancestor(int'(node), int'(other));
			end
			answers_due = {answers_due, typed_answer};
		end
	endtask

	// hold the sender off until every pending answer is back
	task automatic drain_answers();
		start <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	initial begin
		int node;
		int other;
		int pick;
		arst_n           <= 1'b0;
		start            <= 1'b0;
		operation        <= OP_LOAD;
		node_a           <= '0;
		node_b_or_parent <= '0;
		idle_pct         = 15;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 15 : (phase == 1) ? 68 : 0;
			if (phase == 0) begin
				foreach (DIRECTED_WORDS[i])
					apply_word(DIRECTED_WORDS[i].op, DIRECTED_WORDS[i].node,
						DIRECTED_WORDS[i].other, DIRECTED_WORDS[i].typed,
						DIRECTED_WORDS[i].ancestor, DIRECTED_WORDS[i].walk_error);
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (loaded_nodes.size() < 30 || $urandom_range(0, 99) < 35) begin
					if (loaded_nodes.size() < NODES && $urandom_range(0, 99) < 70) begin
						do node = $urandom_range(0, NODES - 1); while (node_loaded[node]);
					end else begin
						node = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
					end
					if ($urandom_range(0, 99) < 65)
						other = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
					else
						other = -1 - int'($urandom_range(0, 1023));
					apply_word(OP_LOAD, NODE_W'(node), PAR_W'(other), 1'b0, NO_NODE, 1'b0);
				end else begin
					node = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
					pick = $urandom_range(0, 99);
					if (pick < 75)
						other = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
					else if (pick < 88)
						other = int'(parent_copy[node]);
					else
						other = -1 - int'($urandom_range(0, 1023));
					apply_word(OP_QUERY, NODE_W'(node), PAR_W'(other), 1'b0, NO_NODE, 1'b0);
				end
			end
			drain_answers();
		end
		repeat (16) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		lca_answer_t want;
		if (arst_n && result_strobe) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: ancestor %0d walk_error %0b", ancestor, walk_error);
			end else begin
				want = answers_due.pop_front();
				if (want.ancestor !== ancestor || want.walk_error !== walk_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: ancestor exp %0d got %0d, walk_error exp %0b got %0b",
							want.ancestor, ancestor, want.walk_error, walk_error);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
